// ===== hw/rtl/erfc_with_slope_fast_exp_macros.svh =====
// erfc_with_slope_fast_exp_macros.svh: assertion macros for the erfc/slope checker.
// Needs nothing but a clock, an active-low reset and the signals under test.
`ifndef ERFC_WITH_SLOPE_FAST_EXP_MACROS_SVH
`define ERFC_WITH_SLOPE_FAST_EXP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERFCSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold after the delay n, counted from the antecedent.
`define ERFCSE_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/erfcse_pkg.sv =====
`timescale 1ns / 1ps
// erfcse_pkg: widths, fixed-point constants and shared types of the erfc/slope pipeline.
// Used by the top level, its cells and its checker; depends on nothing.
package erfcse_pkg;

	localparam int FRAC       = 32;
	localparam int X_W        = 32;
	localparam int X_FRAC     = 26;
	localparam int DIV_CELLS  = 32;
	localparam int D_W        = 36;
	localparam int ACC_W      = 36;
	localparam int ARG_W      = 34;
	localparam int MAG_W      = 33;
	localparam int PM_W       = 2 * MAG_W - FRAC;
	localparam int E_W        = 33;
	localparam int INV_W      = 33;
	localparam int YQ_W       = 43;
	localparam int YR_W       = 38;
	localparam int K_W        = 6;
	localparam int HORNER_LAT = 2;
	localparam int ERF_CELLS  = 5;
	localparam int EXP_CELLS  = 7;
	localparam int PIPE_LAT   = 2 + DIV_CELLS + ERF_CELLS * HORNER_LAT + 2;
	localparam int NEG_DLY    = PIPE_LAT - 3;
	localparam int KF_DLY     = 1 + EXP_CELLS * HORNER_LAT;
	localparam int E_DLY      = DIV_CELLS + ERF_CELLS * HORNER_LAT
		- (3 + EXP_CELLS * HORNER_LAT + 1);

	localparam logic [63:0] DEC9  = 64'd1000000000;
	localparam logic [63:0] HALF9 = 64'd500000000;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [D_W-1:0]       rem;
		logic [D_W-1:0]       den;
		logic [DIV_CELLS-1:0] quo;
	} div_t;

	typedef struct packed {
		logic           flush;
		logic [K_W-1:0] k;
	} kf_t;

	// Q32 value of ip + hi/1e9 + lo/1e18, rounded to nearest.
	function automatic logic [63:0] qc(input logic [63:0] ip, input logic [63:0] hi,
		input logic [63:0] lo);
		return (ip << 32) + (((hi << 32) + ((lo << 32) / DEC9) + HALF9) / DEC9);
	endfunction

	localparam logic [31:0] ERF_P32 = 32'(qc(64'd0, 64'd327591100, 64'd0));

	localparam acc_t ERF_C1 = acc_t'(qc(64'd0, 64'd254829592, 64'd0));
	localparam acc_t ERF_C2 = acc_t'(64'd0 - qc(64'd0, 64'd284496736, 64'd0));
	localparam acc_t ERF_C3 = acc_t'(qc(64'd1, 64'd421413741, 64'd0));
	localparam acc_t ERF_C4 = acc_t'(64'd0 - qc(64'd1, 64'd453152027, 64'd0));
	localparam acc_t ERF_C5 = acc_t'(qc(64'd1, 64'd61405429, 64'd0));

	localparam logic [INV_W-1:0] INV_LN2 = INV_W'(qc(64'd1, 64'd442695040, 64'd888963400));
	localparam logic [31:0]      LN2_Q   = 32'(qc(64'd0, 64'd693147180, 64'd559945300));

	localparam acc_t EX_ONE = acc_t'(64'd1 << FRAC);
	localparam acc_t EX_C1  = acc_t'(64'd0 - qc(64'd0, 64'd999999999, 64'd500000000));
	localparam acc_t EX_C2  = acc_t'(qc(64'd0, 64'd499999920, 64'd600000000));
	localparam acc_t EX_C3  = acc_t'(64'd0 - qc(64'd0, 64'd166665301, 64'd900000000));
	localparam acc_t EX_C4  = acc_t'(qc(64'd0, 64'd41657347, 64'd500000000));
	localparam acc_t EX_C5  = acc_t'(64'd0 - qc(64'd0, 64'd8301359, 64'd800000000));
	localparam acc_t EX_C6  = acc_t'(qc(64'd0, 64'd1329882, 64'd0));
	localparam acc_t EX_C7  = acc_t'(64'd0 - qc(64'd0, 64'd141316, 64'd100000000));

	localparam logic [E_W-1:0] SLOPE_K =
		E_W'(qc(64'd0, 64'd564189583, 64'd547756280) << 1);

	localparam acc_t ERF_COEF [ERF_CELLS] = '{ERF_C4, ERF_C3, ERF_C2, ERF_C1, acc_t'(0)};
	localparam acc_t EXP_COEF [EXP_CELLS] = '{EX_C6, EX_C5, EX_C4, EX_C3, EX_C2, EX_C1,
		EX_ONE};

endpackage

// ===== hw/rtl/erfcse_div_cell.sv =====
`timescale 1ns / 1ps
// erfcse_div_cell: one restoring-division cell that produces one quotient bit per stage.
// Depends on erfcse_pkg for the division record type.
module erfcse_div_cell (
	input  logic             clk,
	input  erfcse_pkg::div_t div_i,
	output erfcse_pkg::div_t div_o
);

	logic [erfcse_pkg::D_W:0] trial;
	logic [erfcse_pkg::D_W:0] diff;
	logic                     take;
	erfcse_pkg::div_t         div_s1;

	assign trial = {div_i.rem, 1'b1};
	assign diff  = trial - {1'b0, div_i.den};
	assign take  = (trial >= {1'b0, div_i.den});

	always_ff @(posedge clk) begin
		div_s1.rem <= take ? diff[erfcse_pkg::D_W-1:0] : trial[erfcse_pkg::D_W-1:0];
		div_s1.den <= div_i.den;
		div_s1.quo <= {div_i.quo[erfcse_pkg::DIV_CELLS-2:0], take};
	end

	assign div_o = div_s1;

endmodule

// ===== hw/rtl/erfcse_horner_cell.sv =====
`timescale 1ns / 1ps
// erfcse_horner_cell: one two-stage Horner step, acc * arg in Q32 truncated toward zero plus coef.
// Depends on erfcse_pkg for widths.
module erfcse_horner_cell (
	input  logic                                clk,
	input  logic signed [erfcse_pkg::ACC_W-1:0] acc_i,
	input  logic signed [erfcse_pkg::ARG_W-1:0] arg_i,
	input  logic signed [erfcse_pkg::ACC_W-1:0] coef_i,
	output logic signed [erfcse_pkg::ACC_W-1:0] acc_o,
	output logic signed [erfcse_pkg::ARG_W-1:0] arg_o
);

	logic [erfcse_pkg::ACC_W-1:0]        a_abs;
	logic [erfcse_pkg::ARG_W-1:0]        v_abs;
	logic [2*erfcse_pkg::MAG_W-1:0]      prod;
	logic [erfcse_pkg::ACC_W-1:0]        p_ext;
	logic [erfcse_pkg::PM_W-1:0]         pmag_s1;
	logic                                pneg_s1;
	logic signed [erfcse_pkg::ARG_W-1:0] arg_s1;
	logic signed [erfcse_pkg::ACC_W-1:0] acc_s2;
	logic signed [erfcse_pkg::ARG_W-1:0] arg_s2;

	assign a_abs = acc_i[erfcse_pkg::ACC_W-1] ? -acc_i : acc_i;
	assign v_abs = arg_i[erfcse_pkg::ARG_W-1] ? -arg_i : arg_i;
	assign prod  = a_abs[erfcse_pkg::MAG_W-1:0] * v_abs[erfcse_pkg::MAG_W-1:0];

	always_ff @(posedge clk) begin
		pmag_s1 <= prod[2*erfcse_pkg::MAG_W-1:erfcse_pkg::FRAC];
		pneg_s1 <= acc_i[erfcse_pkg::ACC_W-1] ^ arg_i[erfcse_pkg::ARG_W-1];
		arg_s1  <= arg_i;
	end

	assign p_ext = {{(erfcse_pkg::ACC_W-erfcse_pkg::PM_W){1'b0}}, pmag_s1};

	always_ff @(posedge clk) begin
		acc_s2 <= $signed(pneg_s1 ? -p_ext : p_ext) + coef_i;
		arg_s2 <= arg_s1;
	end

	assign acc_o = acc_s2;
	assign arg_o = arg_s2;

endmodule

// ===== hw/rtl/erfc_with_slope_fast_exp.sv =====
`timescale 1ns / 1ps
// erfc_with_slope_fast_exp: pipelined erfc(x) and slope -2/sqrt(pi)*exp(-x*x) for Q5.26 x.
// Depends on erfcse_pkg, erfcse_div_cell and erfcse_horner_cell.
//
// The block takes one transaction in every clock cycle: busy is always low, so a start
// is accepted at every rising edge at which it is high. Each result appears on
// erfc_value and slope for exactly one cycle with done high, in the order of
// acceptance. The erfc path runs through the chain of 32 division cells that forms
// t = 1/(1+p|x|), one quotient bit per cell, and then through five two-stage Horner
// cells for the erfc polynomial; the exponential runs alongside in seven Horner cells.
// The receiver cannot stall the pipeline.
module erfc_with_slope_fast_exp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [erfcse_pkg::X_W-1:0] x_value,
	output logic        done,
	output logic [31:0] erfc_value,
	output logic signed [31:0] slope
);

	localparam logic [erfcse_pkg::D_W-1:0] D_ONE =
		erfcse_pkg::D_W'(64'd1 << erfcse_pkg::FRAC);
	localparam logic [erfcse_pkg::D_W-1:0] REM_INIT =
		erfcse_pkg::D_W'((64'd1 << erfcse_pkg::FRAC) - 64'd1);
	localparam logic [erfcse_pkg::PM_W-1:0] V_TWO =
		erfcse_pkg::PM_W'(64'd1 << (erfcse_pkg::FRAC + 1));
	localparam logic [erfcse_pkg::PM_W-1:0] RND = erfcse_pkg::PM_W'(2);

	logic [erfcse_pkg::PIPE_LAT-1:0] vld_q;

	logic [erfcse_pkg::X_W-1:0] x_raw;
	logic [erfcse_pkg::X_W-1:0] ax_s1;
	logic                       neg_s1;
	logic [erfcse_pkg::NEG_DLY-1:0] neg_dly_q;

	logic [2*erfcse_pkg::X_W-1:0] px;
	logic [2*erfcse_pkg::X_W-1:0] sq;
	logic [erfcse_pkg::D_W-1:0]   d_s2;
	logic [erfcse_pkg::YQ_W-1:0]  yq_s2;

	logic [erfcse_pkg::FRAC+erfcse_pkg::INV_W-1:0] zl;
	logic [erfcse_pkg::FRAC+erfcse_pkg::INV_W-1:0] zp_s3;
	logic [erfcse_pkg::YR_W-1:0]                   yr_s3;
	logic                                          big_s3;

	logic [erfcse_pkg::YR_W-erfcse_pkg::FRAC+erfcse_pkg::INV_W-1:0] zh;
	logic [erfcse_pkg::YR_W+erfcse_pkg::INV_W-1:0]                  zsum;
	logic [erfcse_pkg::K_W:0]                                       kw;
	erfcse_pkg::kf_t                                                kf_s4;
	logic [erfcse_pkg::YR_W-1:0]                                    yr_s4;

	logic [erfcse_pkg::YR_W-1:0]           kl;
	logic [erfcse_pkg::YR_W:0]             bd;
	logic signed [erfcse_pkg::ARG_W-1:0]   b_s5;
	erfcse_pkg::kf_t                       kf_dly_q [erfcse_pkg::KF_DLY];

	erfcse_pkg::acc_t                    ex_acc [erfcse_pkg::EXP_CELLS+1];
	logic signed [erfcse_pkg::ARG_W-1:0] ex_arg [erfcse_pkg::EXP_CELLS];
	erfcse_pkg::acc_t                    pe;
	erfcse_pkg::kf_t                     kf_end;
	logic                                pe_pos;
	logic [erfcse_pkg::E_W-1:0]          e_s20;
	logic [erfcse_pkg::E_W-1:0]          e_dly_q [erfcse_pkg::E_DLY];

	erfcse_pkg::div_t div_c [erfcse_pkg::DIV_CELLS+1];

	erfcse_pkg::acc_t                    erf_acc [erfcse_pkg::ERF_CELLS+1];
	logic signed [erfcse_pkg::ARG_W-1:0] erf_arg [erfcse_pkg::ERF_CELLS];

	logic [erfcse_pkg::ACC_W-1:0]   q_abs;
	logic [2*erfcse_pkg::MAG_W-1:0] pm;
	logic [2*erfcse_pkg::E_W-1:0]   sm;
	logic [erfcse_pkg::PM_W-1:0]    pmag_s45;
	logic                           psgn_s45;
	logic [erfcse_pkg::PM_W-1:0]    smag_s45;
	logic                           neg_s45;

	logic [erfcse_pkg::PM_W-1:0] prodc;
	logic [erfcse_pkg::PM_W-1:0] vsel;
	logic [erfcse_pkg::PM_W-1:0] vr;
	logic [erfcse_pkg::PM_W:0]   sr;
	logic [31:0]                 erfc_s46;
	logic signed [31:0]          slope_s46;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[erfcse_pkg::PIPE_LAT-2:0], start & ~busy};
		end
	end

	assign x_raw = x_value;

	always_ff @(posedge clk) begin
		ax_s1     <= x_raw[erfcse_pkg::X_W-1] ? -x_raw : x_raw;
		neg_s1    <= x_raw[erfcse_pkg::X_W-1];
		neg_dly_q <= {neg_dly_q[erfcse_pkg::NEG_DLY-2:0], neg_s1};
	end

	assign px = ax_s1 * erfcse_pkg::ERF_P32;
	assign sq = ax_s1 * ax_s1;

	always_ff @(posedge clk) begin
		d_s2  <= D_ONE + px[erfcse_pkg::X_FRAC +: erfcse_pkg::D_W];
		yq_s2 <= sq[2*erfcse_pkg::X_FRAC-erfcse_pkg::FRAC +: erfcse_pkg::YQ_W];
	end

	assign zl = yq_s2[erfcse_pkg::FRAC-1:0] * erfcse_pkg::INV_LN2;

	always_ff @(posedge clk) begin
		zp_s3  <= zl;
		yr_s3  <= yq_s2[erfcse_pkg::YR_W-1:0];
		big_s3 <= |yq_s2[erfcse_pkg::YQ_W-1:erfcse_pkg::YR_W];
	end

	assign zh   = yr_s3[erfcse_pkg::YR_W-1:erfcse_pkg::FRAC] * erfcse_pkg::INV_LN2;
	assign zsum = {zh, {erfcse_pkg::FRAC{1'b0}}}
		+ (erfcse_pkg::YR_W+erfcse_pkg::INV_W)'(zp_s3);
	assign kw   = zsum[erfcse_pkg::YR_W+erfcse_pkg::INV_W-1:2*erfcse_pkg::FRAC];

	always_ff @(posedge clk) begin
		kf_s4.k     <= kw[erfcse_pkg::K_W-1:0];
		kf_s4.flush <= big_s3 | kw[erfcse_pkg::K_W];
		yr_s4       <= yr_s3;
	end

	assign kl = kf_s4.k * erfcse_pkg::LN2_Q;
	assign bd = {1'b0, yr_s4} - {1'b0, kl};

	always_ff @(posedge clk) begin
		b_s5        <= $signed(bd[erfcse_pkg::ARG_W-1:0]);
		kf_dly_q[0] <= kf_s4;
		for (int i = 1; i < erfcse_pkg::KF_DLY; i++) begin
			kf_dly_q[i] <= kf_dly_q[i-1];
		end
	end

	assign ex_acc[0] = erfcse_pkg::EX_C7;
	assign ex_arg[0] = b_s5;

	for (genvar g = 0; g < erfcse_pkg::EXP_CELLS; g++) begin : g_exp
		if (g < erfcse_pkg::EXP_CELLS - 1) begin : g_mid
			erfcse_horner_cell u_cell (
				.clk    (clk),
				.acc_i  (ex_acc[g]),
				.arg_i  (ex_arg[g]),
				.coef_i (erfcse_pkg::EXP_COEF[g]),
				.acc_o  (ex_acc[g+1]),
				.arg_o  (ex_arg[g+1])
			);
		end else begin : g_end
			erfcse_horner_cell u_cell (
				.clk    (clk),
				.acc_i  (ex_acc[g]),
				.arg_i  (ex_arg[g]),
				.coef_i (erfcse_pkg::EXP_COEF[g]),
				.acc_o  (ex_acc[g+1]),
				.arg_o  ()
			);
		end
	end

	assign pe     = ex_acc[erfcse_pkg::EXP_CELLS];
	assign kf_end = kf_dly_q[erfcse_pkg::KF_DLY-1];
	assign pe_pos = !pe[erfcse_pkg::ACC_W-1] && (pe != '0);

	always_ff @(posedge clk) begin
		e_s20 <= (pe_pos && !kf_end.flush) ? (pe[erfcse_pkg::E_W-1:0] >> kf_end.k) : '0;
		e_dly_q[0] <= e_s20;
		for (int i = 1; i < erfcse_pkg::E_DLY; i++) begin
			e_dly_q[i] <= e_dly_q[i-1];
		end
	end

	assign div_c[0] = '{rem: REM_INIT, den: d_s2, quo: '0};

	for (genvar g = 0; g < erfcse_pkg::DIV_CELLS; g++) begin : g_div
		erfcse_div_cell u_cell (
			.clk   (clk),
			.div_i (div_c[g]),
			.div_o (div_c[g+1])
		);
	end

	assign erf_acc[0] = erfcse_pkg::ERF_C5;
	assign erf_arg[0] = $signed({{(erfcse_pkg::ARG_W-erfcse_pkg::DIV_CELLS){1'b0}},
		div_c[erfcse_pkg::DIV_CELLS].quo});

	for (genvar g = 0; g < erfcse_pkg::ERF_CELLS; g++) begin : g_erf
		if (g < erfcse_pkg::ERF_CELLS - 1) begin : g_mid
			erfcse_horner_cell u_cell (
				.clk    (clk),
				.acc_i  (erf_acc[g]),
				.arg_i  (erf_arg[g]),
				.coef_i (erfcse_pkg::ERF_COEF[g]),
				.acc_o  (erf_acc[g+1]),
				.arg_o  (erf_arg[g+1])
			);
		end else begin : g_end
			erfcse_horner_cell u_cell (
				.clk    (clk),
				.acc_i  (erf_acc[g]),
				.arg_i  (erf_arg[g]),
				.coef_i (erfcse_pkg::ERF_COEF[g]),
				.acc_o  (erf_acc[g+1]),
				.arg_o  ()
			);
		end
	end

	assign q_abs = erf_acc[erfcse_pkg::ERF_CELLS][erfcse_pkg::ACC_W-1]
		? -erf_acc[erfcse_pkg::ERF_CELLS] : erf_acc[erfcse_pkg::ERF_CELLS];
	assign pm = q_abs[erfcse_pkg::MAG_W-1:0] * e_dly_q[erfcse_pkg::E_DLY-1];
	assign sm = erfcse_pkg::SLOPE_K * e_dly_q[erfcse_pkg::E_DLY-1];

	always_ff @(posedge clk) begin
		pmag_s45 <= pm[2*erfcse_pkg::MAG_W-1:erfcse_pkg::FRAC];
		psgn_s45 <= erf_acc[erfcse_pkg::ERF_CELLS][erfcse_pkg::ACC_W-1];
		smag_s45 <= sm[2*erfcse_pkg::E_W-1:erfcse_pkg::FRAC];
		neg_s45  <= neg_dly_q[erfcse_pkg::NEG_DLY-1];
	end

	always_comb begin
		if (psgn_s45 && (pmag_s45 != '0)) begin
			prodc = '0;
		end else if (pmag_s45 > V_TWO) begin
			prodc = V_TWO;
		end else begin
			prodc = pmag_s45;
		end
		vsel = neg_s45 ? (V_TWO - prodc) : prodc;
		vr   = vsel + RND;
		sr   = {1'b0, smag_s45} + {1'b0, RND};
	end

	always_ff @(posedge clk) begin
		erfc_s46  <= vr[erfcse_pkg::PM_W-1:2];
		slope_s46 <= $signed(32'd0 - sr[33:2]);
	end

	assign done       = vld_q[erfcse_pkg::PIPE_LAT-1];
	assign erfc_value = erfc_s46;
	assign slope      = slope_s46;

endmodule

// ===== hw/rtl/erfcse_checker.sv =====
`timescale 1ns / 1ps
// erfcse_checker: port-level assertions on timing and result ranges of the erfc/slope block.
// Depends on erfcse_pkg and erfc_with_slope_fast_exp_macros.svh; bound to the top level below.
`include "erfc_with_slope_fast_exp_macros.svh"

module erfcse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] erfc_value,
	input logic signed [31:0] slope
);

	`ERFCSE_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy, "busy went high")
	`ERFCSE_ASSERT_DELAY(a_result_follows, clk, arst_n, start && !busy, erfcse_pkg::PIPE_LAT, done, "accepted transaction gave no result")
	`ERFCSE_ASSERT_IMPL(a_result_has_cause, clk, arst_n, done, $past(start && !busy, erfcse_pkg::PIPE_LAT), "result without an accepted transaction")
	`ERFCSE_ASSERT_IMPL(a_result_range, clk, arst_n, done, (erfc_value <= 32'h8000_0000) && (slope == 32'sd0 || slope[31]), "result out of range")

endmodule

bind erfc_with_slope_fast_exp erfcse_checker u_erfcse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.erfc_value (erfc_value),
	.slope      (slope)
);
